// ===== rtl/xtea1_pkg.sv =====
// ----------------------------------------------------------------------------
// XTEA-1 cipher package
// Request and result types, round constants and the per-stage round control.
// ----------------------------------------------------------------------------
`default_nettype none

package xtea1_pkg;

    localparam int unsigned ROUND_COUNT = 32;
    localparam int unsigned STAGES      = 2 * ROUND_COUNT;
    localparam int unsigned KEY_WORDS   = 4;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned WORD_W      = 32;

    localparam logic [WORD_W-1:0] DELTA = 32'h9E3779B9;

    // operation codes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 3'd3;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] t_key;

    typedef struct packed {
        logic              req_type;
        logic [WORD_W-1:0] block_word_0;
        logic [WORD_W-1:0] block_word_1;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0] result_word_0;
        logic [WORD_W-1:0] result_word_1;
    } t_result;

    // block as it travels down the pipeline
    typedef struct packed {
        logic              mode;
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w1;
    } t_lane;

    // fixed control of one half-round stage, for both directions
    typedef struct packed {
        logic              odd;
        logic [WORD_W-1:0] sum_enc;
        logic [WORD_W-1:0] sum_dec;
        logic [1:0]        kidx_enc;
        logic [1:0]        kidx_dec;
    } t_stage_ctl;

    function automatic t_stage_ctl stage_ctl(input int unsigned h);
        t_stage_ctl        c;
        logic [WORD_W-1:0] r;
        logic [WORD_W-1:0] n;
        r = WORD_W'(h >> 1);
        n = WORD_W'(ROUND_COUNT);
        c.odd = h[0];
        if (h[0] == 1'b0) begin
            // first half of a round: encrypt updates w0, decrypt updates w1
            c.sum_enc  = r * DELTA;
            c.sum_dec  = (n - r) * DELTA;
            c.kidx_enc = c.sum_enc[1:0];
            c.kidx_dec = c.sum_dec[12:11];
        end else begin
            c.sum_enc  = (r + 32'd1) * DELTA;
            c.sum_dec  = (n - r - 32'd1) * DELTA;
            c.kidx_enc = c.sum_enc[12:11];
            c.kidx_dec = c.sum_dec[1:0];
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/xtea1_round.sv =====
// ----------------------------------------------------------------------------
// XTEA-1 half-round stage
// One registered half-round: mixes one word and adds it to, or subtracts it
// from, the other word, depending on the direction carried with the block.
// ----------------------------------------------------------------------------
`default_nettype none

module xtea1_round (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    input  xtea1_pkg::t_lane              i_lane,
    input  xtea1_pkg::t_stage_ctl         i_ctl,
    input  xtea1_pkg::t_key               i_key,
    output logic                          o_valid,
    output xtea1_pkg::t_lane              o_lane
);

    logic                  r_valid;
    xtea1_pkg::t_lane      r_lane;
    xtea1_pkg::t_lane      n_lane;

    logic                  upd_w0;
    logic [31:0]           x;
    logic [31:0]           tgt;
    logic [31:0]           sum;
    logic [1:0]            kidx;
    logic [31:0]           kword;
    logic [63:0]           krot;
    logic [31:0]           mix;
    logic [31:0]           tgt_next;

    always_comb begin
        // encrypt even / decrypt odd update w0, the other cases update w1
        upd_w0   = ~(i_ctl.odd ^ i_lane.mode);
        x        = upd_w0 ? i_lane.w1 : i_lane.w0;
        tgt      = upd_w0 ? i_lane.w0 : i_lane.w1;
        sum      = (i_lane.mode == xtea1_pkg::OP_DECRYPT) ? i_ctl.sum_dec : i_ctl.sum_enc;
        kidx     = (i_lane.mode == xtea1_pkg::OP_DECRYPT) ? i_ctl.kidx_dec : i_ctl.kidx_enc;
        kword    = i_key[kidx];
        krot     = {kword, kword} << x[4:0];
        mix      = (((x << 4) ^ (x >> 5)) + (x ^ sum)) + krot[63:32];
        tgt_next = (i_lane.mode == xtea1_pkg::OP_DECRYPT) ? (tgt - mix) : (tgt + mix);

        n_lane      = i_lane;
        if (upd_w0) begin
            n_lane.w0 = tgt_next;
        end else begin
            n_lane.w1 = tgt_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

`default_nettype wire

// ===== rtl/xtea1_block_cipher.sv =====
// ----------------------------------------------------------------------------
// XTEA-1 block cipher
// Fully pipelined encrypt/decrypt of one 64-bit block under a 128-bit key.
// ----------------------------------------------------------------------------
// Usage:
//   Key words 0..3 are written through i_cfg_we / i_cfg_idx / i_cfg_data;
//   indexes above 3 are ignored. Write the key only while no request is in
//   flight.
//   A request (i_req: req_type, block_word_0, block_word_1) is taken at a
//   rising edge with start high and busy low. busy is low whenever the block
//   is out of reset, so one request can enter every cycle.
//   Each request yields one result on o_result, marked by o_done for exactly
//   one cycle, after it has passed through all half-round stages, in
//   request order. Throughput is one block per cycle: each of the 64
//   half-round stages holds one adder chain and one key rotator.
//   The receiver cannot stall; results are not held.
//   Reset clears all stage valid bits and the key registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module xtea1_block_cipher (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  xtea1_pkg::t_req                       i_req,
    output logic                                  o_done,
    output xtea1_pkg::t_result                    o_result,
    input  wire                                   i_cfg_we,
    input  wire  [xtea1_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [xtea1_pkg::WORD_W-1:0]          i_cfg_data
);

    localparam int unsigned NS = xtea1_pkg::STAGES;

    xtea1_pkg::t_key   r_key;
    xtea1_pkg::t_lane  w_lane  [NS+1];
    logic              w_valid [NS+1];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we && (i_cfg_idx <= xtea1_pkg::REG_KEY_WORD_3)) begin
            r_key[i_cfg_idx[1:0]] <= i_cfg_data;
        end
    end

    assign busy = ~i_rst_n;

    assign w_valid[0]     = start & ~busy;
    assign w_lane[0].mode = i_req.req_type;
    assign w_lane[0].w0   = i_req.block_word_0;
    assign w_lane[0].w1   = i_req.block_word_1;

    for (genvar g = 0; g < NS; g++) begin : g_stage
        localparam xtea1_pkg::t_stage_ctl CTL = xtea1_pkg::stage_ctl(g);
        xtea1_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_lane  (w_lane[g]),
            .i_ctl   (CTL),
            .i_key   (r_key),
            .o_valid (w_valid[g+1]),
            .o_lane  (w_lane[g+1])
        );
    end

    assign o_done                 = w_valid[NS];
    assign o_result.result_word_0 = w_lane[NS].w0;
    assign o_result.result_word_1 = w_lane[NS].w1;

`ifndef SYNTHESIS
    // every result traces back to a request that passed through every stage
    a_done_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, NS))
        else $error("result without matching request");

    // a request taken with no reset in flight comes out of the last stage
    a_request_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##NS o_done)
        else $error("request did not complete after the pipeline depth");

    // writes beyond the key registers leave the key untouched
    a_key_ignore_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_idx > xtea1_pkg::REG_KEY_WORD_3)) |=> $stable(r_key))
        else $error("key changed by out-of-range write");

    // the first key register follows a write to its index
    a_key0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_idx == xtea1_pkg::REG_KEY_WORD_0))
            |=> (r_key[0] == $past(i_cfg_data)))
        else $error("key word 0 not written");
`endif

endmodule

`default_nettype wire
